FILE: hdl/sic_pkg.sv
package sic_pkg;

	localparam int CoordWidth = 16;

	localparam logic [2:0] REL_COLLINEAR  = 3'd0;
	localparam logic [2:0] REL_PARALLEL   = 3'd1;
	localparam logic [2:0] REL_SEG_CROSS  = 3'd2;
	localparam logic [2:0] REL_A_BISECTS  = 3'd3;
	localparam logic [2:0] REL_B_BISECTS  = 3'd4;
	localparam logic [2:0] REL_LINE_CROSS = 3'd5;

	typedef struct packed {
		logic signed [CoordWidth-1:0] a_x;
		logic signed [CoordWidth-1:0] a_y;
		logic signed [CoordWidth-1:0] b_x;
		logic signed [CoordWidth-1:0] b_y;
		logic signed [CoordWidth-1:0] c_x;
		logic signed [CoordWidth-1:0] c_y;
		logic signed [CoordWidth-1:0] d_x;
		logic signed [CoordWidth-1:0] d_y;
	} seg_pair_t;

	typedef struct packed {
		logic [2:0]                   relation;
		logic signed [CoordWidth-1:0] cross_x;
		logic signed [CoordWidth-1:0] cross_y;
		logic                         point_valid;
		logic                         clipped;
	} seg_result_t;

endpackage

FILE: hdl/sic_divider.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// Operates on magnitudes; sign restored at the output. Carries a tag alongside.
module sic_divider import sic_pkg::*; #(
	parameter int NumWidth = 64,
	parameter int DenWidth = 48,
	parameter int TagWidth = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [NumWidth-1:0] num,
	input  logic signed [DenWidth-1:0] den,
	input  logic [TagWidth-1:0]        tag_in,
	output logic                       out_valid,
	output logic signed [NumWidth-1:0] quot,
	output logic [TagWidth-1:0]        tag_out
);
	localparam int Stages = NumWidth;

	logic                v_q   [Stages+1];
	logic [NumWidth-1:0] q_q   [Stages+1];
	logic [DenWidth:0]   r_q   [Stages+1];
	logic [DenWidth-1:0] d_q   [Stages+1];
	logic                neg_q [Stages+1];
	logic [TagWidth-1:0] t_q   [Stages+1];

	logic [NumWidth-1:0] num_mag;
	logic [DenWidth-1:0] den_mag;

	always_comb begin
		num_mag = num[NumWidth-1] ? NumWidth'(-num) : NumWidth'(num);
		den_mag = den[DenWidth-1] ? DenWidth'(-den) : DenWidth'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q[0]   <= num_mag;
			r_q[0]   <= '0;
			d_q[0]   <= den_mag;
			neg_q[0] <= num[NumWidth-1] ^ den[DenWidth-1];
			t_q[0]   <= tag_in;
		end
	end

	for (genvar i = 0; i < Stages; i++) begin : g_stage
		logic [DenWidth+1:0] trial;
		logic [DenWidth+1:0] shifted;
		always_comb begin
			shifted = {r_q[i], q_q[i][NumWidth-1]};
			trial   = shifted - {2'b00, d_q[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (en) begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[DenWidth+1]) begin
					r_q[i+1] <= trial[DenWidth:0];
					q_q[i+1] <= {q_q[i][NumWidth-2:0], 1'b1};
				end else begin
					r_q[i+1] <= shifted[DenWidth:0];
					q_q[i+1] <= {q_q[i][NumWidth-2:0], 1'b0};
				end
				d_q[i+1]   <= d_q[i];
				neg_q[i+1] <= neg_q[i];
				t_q[i+1]   <= t_q[i];
			end
		end
	end

	assign out_valid = v_q[Stages];
	assign quot      = neg_q[Stages] ? NumWidth'(-q_q[Stages]) : NumWidth'(q_q[Stages]);
	assign tag_out   = t_q[Stages];

endmodule

FILE: hdl/sic_front.sv
// Differences, cross products and classification.
module sic_front import sic_pkg::*; #(
	parameter int CW = CoordWidth
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [CW-1:0]      ax,
	input  logic signed [CW-1:0]      ay,
	input  logic signed [CW-1:0]      bx,
	input  logic signed [CW-1:0]      by,
	input  logic signed [CW-1:0]      cx,
	input  logic signed [CW-1:0]      cy,
	input  logic signed [CW-1:0]      dx,
	input  logic signed [CW-1:0]      dy,
	output logic                      out_valid,
	output logic [2:0]                rel,
	output logic                      den_nz,
	output logic signed [4*CW+5:0]    px_num,
	output logic signed [4*CW+5:0]    py_num,
	output logic signed [2*CW+2:0]    den_out
);
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int QW = 4 * CW + 6;

	// stage 1: differences
	logic              v_s1;
	logic signed [DW-1:0] acy_s1, dcx_s1, acx_s1, dcy_s1, bax_s1, bay_s1;
	logic signed [CW-1:0] ax_s1, ay_s1;

	// stage 2: products
	logic              v_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [DW-1:0] bax_s2, bay_s2;
	logic signed [CW-1:0] ax_s2, ay_s2;

	// stage 3: cross products
	logic              v_s3;
	logic signed [XW-1:0] num_s3, den_s3, num2_s3;
	logic signed [DW-1:0] bax_s3, bay_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;

	// stage 4: class, point numerator products
	logic              v_s4;
	logic [2:0]        rel_s4;
	logic              nz_s4;
	logic signed [QW-1:0] m1_s4, m2_s4, m3_s4, m4_s4;
	logic signed [XW-1:0] den_s4;

	// stage 5: point numerators
	logic              v_s5;
	logic [2:0]        rel_s5;
	logic              nz_s5;
	logic signed [QW-1:0] pxn_s5, pyn_s5;
	logic signed [XW-1:0] den_s5;

	logic ab, cd;
	logic [2:0] rel_c;

	always_comb begin
		logic signed [XW-1:0] z;
		z = '0;
		if (!den_s3[XW-1]) begin
			ab = (num_s3 >= z) && (num_s3 <= den_s3);
			cd = (num2_s3 >= z) && (num2_s3 <= den_s3);
		end else begin
			ab = (num_s3 >= den_s3) && (num_s3 <= z);
			cd = (num2_s3 >= den_s3) && (num2_s3 <= z);
		end
		priority if (den_s3 == z) rel_c = (num_s3 == z) ? REL_COLLINEAR : REL_PARALLEL;
		else if (ab && cd) rel_c = REL_SEG_CROSS;
		else if (cd) rel_c = REL_A_BISECTS;
		else if (ab) rel_c = REL_B_BISECTS;
		else rel_c = REL_LINE_CROSS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acy_s1 <= DW'(ay) - DW'(cy);
			dcx_s1 <= DW'(dx) - DW'(cx);
			acx_s1 <= DW'(ax) - DW'(cx);
			dcy_s1 <= DW'(dy) - DW'(cy);
			bax_s1 <= DW'(bx) - DW'(ax);
			bay_s1 <= DW'(by) - DW'(ay);
			ax_s1  <= ax;
			ay_s1  <= ay;

			p1_s2  <= PW'(acy_s1) * PW'(dcx_s1);
			p2_s2  <= PW'(acx_s1) * PW'(dcy_s1);
			p3_s2  <= PW'(bax_s1) * PW'(dcy_s1);
			p4_s2  <= PW'(bay_s1) * PW'(dcx_s1);
			p5_s2  <= PW'(acy_s1) * PW'(bax_s1);
			p6_s2  <= PW'(acx_s1) * PW'(bay_s1);
			bax_s2 <= bax_s1;
			bay_s2 <= bay_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;

			num_s3  <= XW'(p1_s2) - XW'(p2_s2);
			den_s3  <= XW'(p3_s2) - XW'(p4_s2);
			num2_s3 <= XW'(p5_s2) - XW'(p6_s2);
			bax_s3  <= bax_s2;
			bay_s3  <= bay_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;

			rel_s4 <= rel_c;
			nz_s4  <= (den_s3 != '0);
			m1_s4  <= QW'(ax_s3) * QW'(den_s3);
			m2_s4  <= QW'(num_s3) * QW'(bax_s3);
			m3_s4  <= QW'(ay_s3) * QW'(den_s3);
			m4_s4  <= QW'(num_s3) * QW'(bay_s3);
			den_s4 <= den_s3;

			rel_s5 <= rel_s4;
			nz_s5  <= nz_s4;
			pxn_s5 <= m1_s4 + m2_s4;
			pyn_s5 <= m3_s4 + m4_s4;
			den_s5 <= den_s4;
		end
	end

	assign out_valid = v_s5;
	assign rel       = rel_s5;
	assign den_nz    = nz_s5;
	assign px_num    = pxn_s5;
	assign py_num    = pyn_s5;
	// zero denominator: divide by one to keep the divider defined
	assign den_out   = nz_s5 ? den_s5 : XW'(1);

endmodule

FILE: hdl/segment_intersection_classifier_unit.sv
// Pipeline: 5 front stages, 4*CoordWidth+7 divider stages and one output register; the
// first front stage loads at input transfer.
// Throughput: one segment pair per cycle unless stalled; long division sets the latency.
// A stall on a valid output freezes the whole pipeline; an output register holds the result.
// Reset: arst_n asynchronously clears all valid bits; payload registers are not reset.
module segment_intersection_classifier_unit import sic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  seg_pair_t   in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output seg_result_t out_data
);
	// payload structs fix the coordinate width in the package
	localparam int CW = CoordWidth;
	localparam int QW = 4 * CW + 6;
	localparam int XW = 2 * CW + 3;
	localparam int TW = 4;

	logic en;
	logic f_valid, f_nz;
	logic [2:0] f_rel;
	logic signed [QW-1:0] f_px, f_py, qx, qy;
	logic signed [XW-1:0] f_den;
	logic dx_valid, dy_valid;
	logic [TW-1:0] tag_x, tag_y;

	logic              v_q;
	seg_result_t       res_q;
	logic signed [CW-1:0] sx, sy;
	logic clip_x, clip_y;

	assign en       = !(v_q && out_stall);
	assign in_stall = !en;

	sic_front #(.CW(CW)) u_front (
		.clk, .arst_n, .en, .in_valid,
		.ax(in_data.a_x), .ay(in_data.a_y), .bx(in_data.b_x), .by(in_data.b_y),
		.cx(in_data.c_x), .cy(in_data.c_y), .dx(in_data.d_x), .dy(in_data.d_y),
		.out_valid(f_valid), .rel(f_rel), .den_nz(f_nz),
		.px_num(f_px), .py_num(f_py), .den_out(f_den)
	);

	sic_divider #(.NumWidth(QW), .DenWidth(XW), .TagWidth(TW)) u_div_x (
		.clk, .arst_n, .en, .in_valid(f_valid), .num(f_px), .den(f_den),
		.tag_in({f_rel, f_nz}), .out_valid(dx_valid), .quot(qx), .tag_out(tag_x)
	);

	sic_divider #(.NumWidth(QW), .DenWidth(XW), .TagWidth(TW)) u_div_y (
		.clk, .arst_n, .en, .in_valid(f_valid), .num(f_py), .den(f_den),
		.tag_in({f_rel, f_nz}), .out_valid(dy_valid), .quot(qy), .tag_out(tag_y)
	);

	always_comb begin
		logic signed [QW-1:0] mx, mn;
		mx = QW'({1'b0, {(CW-1){1'b1}}});
		mn = -mx - QW'(1);
		clip_x = 1'b0;
		clip_y = 1'b0;
		priority if (qx > mx) begin sx = mx[CW-1:0]; clip_x = 1'b1; end
		else if (qx < mn) begin sx = mn[CW-1:0]; clip_x = 1'b1; end
		else sx = qx[CW-1:0];
		priority if (qy > mx) begin sy = mx[CW-1:0]; clip_y = 1'b1; end
		else if (qy < mn) begin sy = mn[CW-1:0]; clip_y = 1'b1; end
		else sy = qy[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= dx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.relation    <= tag_x[TW-1:1];
			res_q.point_valid <= tag_x[0];
			res_q.cross_x     <= tag_x[0] ? sx : '0;
			res_q.cross_y     <= tag_x[0] ? sy : '0;
			res_q.clipped     <= tag_x[0] & (clip_x | clip_y);
		end
	end

	assign out_valid = v_q;
	assign out_data  = res_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dx_valid == dy_valid) else $error("dividers out of step");
	a_tag_match: assert property (@(posedge clk) disable iff (!arst_n)
		dx_valid |-> tag_x == tag_y) else $error("divider tags differ");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.point_valid |->
		out_data.relation == REL_COLLINEAR || out_data.relation == REL_PARALLEL)
		else $error("point missing for crossing lines");

endmodule
